[rtl/vqd_pkg.sv]
package vqd_pkg;

   // Field widths and fixed-point format.
   localparam int MAX_ALLELES = 4;
   localparam int FRAC_BITS   = 8;
   localparam int AD_W        = 16;
   localparam int QUAL_W      = 24;
   localparam int DEPTH_W     = 32;
   localparam int QD_W        = 16;

   // Only the first four allele depths are carried on the bus.
   localparam int SUM_ALLELES = (MAX_ALLELES < 4) ? MAX_ALLELES : 4;
   localparam int SUM_W       = AD_W + 2;

   // Default cap of 35.0, saturated to the register width.
   localparam longint CAP_RAW      = 64'd35 << FRAC_BITS;
   localparam longint CAP_MAX      = (64'd1 << QD_W) - 1;
   localparam longint CAP_RESET    = (CAP_RAW > CAP_MAX) ? CAP_MAX : CAP_RAW;
   localparam logic [QD_W-1:0] QD_CAP_RESET = QD_W'(CAP_RESET);

   // Divider runs one quotient bit per cycle.
   localparam int DIV_STEPS = QUAL_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Job queue between front and back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Stream bus widths.
   localparam int REQ_TDATA_W = 128;
   localparam int RSP_TDATA_W = 56;

   typedef struct packed {
      logic              carries_variant;
      logic              has_ad;
      logic [AD_W-1:0]   ad_ref;
      logic [AD_W-1:0]   ad_alt1;
      logic [AD_W-1:0]   ad_alt2;
      logic [AD_W-1:0]   ad_alt3;
      logic              use_evidence;
      logic [AD_W-1:0]   evidence_count;
      logic [AD_W-1:0]   sample_dp;
      logic              qual_valid;
      logic [QUAL_W-1:0] phred_qual;
      logic              last;
   } vqd_genotype_type;

   typedef struct packed {
      logic               qual_valid;
      logic [QUAL_W-1:0]  qual;
      logic [DEPTH_W-1:0] depth;
   } vqd_job_type;

   typedef struct packed {
      logic               qd_valid;
      logic [QD_W-1:0]    qd;
      logic [DEPTH_W-1:0] depth_used;
   } vqd_result_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIV,
      BACK_DONE
   } back_state_type;

   // Saturating add of two accumulator-width values.
   function automatic logic [DEPTH_W-1:0] sat_add(input logic [DEPTH_W-1:0] a,
                                                   input logic [DEPTH_W-1:0] b);
      logic [DEPTH_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[DEPTH_W] ? {DEPTH_W{1'b1}} : s[DEPTH_W-1:0];
   endfunction

endpackage

[rtl/vqd_front.sv]
module vqd_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  vqd_pkg::vqd_genotype_type gt,
   output logic                     push,
   output vqd_pkg::vqd_job_type     job
);
   import vqd_pkg::*;

   logic [DEPTH_W-1:0] total_ff, total_in;
   logic [DEPTH_W-1:0] restr_ff, restr_in;
   logic [AD_W-1:0]    ad [4];
   logic [SUM_W-1:0]   ad_sum;
   logic [SUM_W-1:0]   alt_sum;
   logic               use_ad;
   logic [DEPTH_W-1:0] add_val;
   logic [DEPTH_W-1:0] total_new;
   logic [DEPTH_W-1:0] restr_new;

   // Sum the allele depths of one genotype.
   always_comb begin
      ad[0] = gt.ad_ref;
      ad[1] = gt.ad_alt1;
      ad[2] = gt.ad_alt2;
      ad[3] = gt.ad_alt3;
      ad_sum = '0;
      for (int i = 0; i < SUM_ALLELES; i++) begin
         ad_sum = ad_sum + SUM_W'(ad[i]);
      end
      alt_sum = ad_sum - SUM_W'(gt.ad_ref);
      use_ad  = gt.has_ad && (ad_sum != '0);
   end

   // Choose the depth contribution and update both accumulators.
   always_comb begin
      if (use_ad) begin
         add_val = DEPTH_W'(ad_sum);
      end else if (gt.use_evidence) begin
         add_val = DEPTH_W'(gt.evidence_count);
      end else begin
         add_val = DEPTH_W'(gt.sample_dp);
      end
      total_new = gt.carries_variant ? sat_add(total_ff, add_val) : total_ff;
      if (gt.carries_variant && use_ad && (alt_sum > SUM_W'(1))) begin
         restr_new = sat_add(restr_ff, add_val);
      end else begin
         restr_new = restr_ff;
      end
   end

   // On the last genotype, hand the variant to the back end and start over.
   always_comb begin
      push           = accept && gt.last;
      job.qual_valid = gt.qual_valid;
      job.qual       = gt.phred_qual;
      job.depth      = (restr_new != '0) ? restr_new : total_new;
      total_in       = total_ff;
      restr_in       = restr_ff;
      if (accept) begin
         if (gt.last) begin
            total_in = '0;
            restr_in = '0;
         end else begin
            total_in = total_new;
            restr_in = restr_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         restr_ff <= '0;
      end else begin
         total_ff <= total_in;
         restr_ff <= restr_in;
      end
   end

endmodule

[rtl/vqd_queue.sv]
module vqd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  vqd_pkg::vqd_job_type push_job,
   input  logic                 pop,
   output vqd_pkg::vqd_job_type pop_job,
   output logic                 full,
   output logic                 empty
);
   import vqd_pkg::*;

   vqd_job_type       mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
   endfunction

   // Pointer and fill count update.
   always_comb begin
      full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
      empty     = (count_ff == '0);
      pop_job   = mem_ff[rd_ptr_ff];
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[rtl/vqd_back.sv]
module vqd_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   input  vqd_pkg::vqd_job_type         q_job,
   output logic                         q_pop,
   input  logic [vqd_pkg::QD_W-1:0]     qd_cap,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output vqd_pkg::vqd_result_type      rsp
);
   import vqd_pkg::*;

   back_state_type     state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [QUAL_W-1:0]  quo_ff;
   logic [DEPTH_W-1:0] rem_ff;
   logic [DEPTH_W-1:0] depth_ff;
   logic               qvalid_ff;
   logic               out_valid_ff, out_valid_in;
   vqd_result_type     out_ff;

   logic               load;
   logic               step;
   logic               out_load;
   logic [DEPTH_W:0]   trial;
   logic               fits;
   logic [DEPTH_W-1:0] rem_next;
   logic [QUAL_W-1:0]  quo_next;
   vqd_result_type     result;

   // One restoring division step.
   always_comb begin
      trial    = {rem_ff, quo_ff[QUAL_W-1]};
      fits     = (trial >= {1'b0, depth_ff});
      rem_next = fits ? DEPTH_W'(trial - {1'b0, depth_ff}) : trial[DEPTH_W-1:0];
      quo_next = {quo_ff[QUAL_W-2:0], fits};
   end

   // Clamp the quotient and mask it when there is no quality or no depth.
   always_comb begin
      result.qd_valid   = qvalid_ff && (depth_ff != '0);
      result.depth_used = depth_ff;
      if (!result.qd_valid) begin
         result.qd = '0;
      end else if (quo_ff > QUAL_W'(qd_cap)) begin
         result.qd = qd_cap;
      end else begin
         result.qd = quo_ff[QD_W-1:0];
      end
   end

   // Sequencer: take a job, divide, then wait for the output register.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      load     = 1'b0;
      step     = 1'b0;
      out_load = 1'b0;
      q_pop    = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               load     = 1'b1;
               cnt_in   = '0;
               state_in = BACK_DIV;
            end
         end
         BACK_DIV: begin
            step   = 1'b1;
            cnt_in = cnt_ff + DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = BACK_DONE;
            end
         end
         BACK_DONE: begin
            if (!out_valid_ff || rsp_ready) begin
               out_load = 1'b1;
               state_in = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Divider datapath and output register.
   always_ff @(posedge clock) begin
      if (load) begin
         quo_ff    <= q_job.qual;
         rem_ff    <= '0;
         depth_ff  <= q_job.depth;
         qvalid_ff <= q_job.qual_valid;
      end else if (step) begin
         quo_ff <= quo_next;
         rem_ff <= rem_next;
      end
      if (out_load) begin
         out_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp       = out_ff;

endmodule

[rtl/variant_quality_by_depth.sv]
// Genotypes are accepted one per cycle while the job queue is not full; the
// depth sums settle in the same cycle. Each variant passes through the queue
// to the back end, which divides one quotient bit per cycle and takes a new
// job only once the last result is loaded; a four-entry queue buffers variants.
// Synchronous active-high reset clears the accumulators, queue and sequencer,
// and loads the quality-by-depth cap with 35.0.
module variant_quality_by_depth (
   input  logic                               clock,
   input  logic                               reset,
   // req_tdata, from bit 0: carries_variant, has_ad, ad_ref, ad_alt1, ad_alt2,
   // ad_alt3, use_evidence, evidence_count, sample_dp, qual_valid, phred_qual,
   // zero fill.
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [vqd_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                               req_tlast,
   // rsp_tdata, from bit 0: qd_valid, qd, depth_used, zero fill.
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [vqd_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [vqd_pkg::QD_W-1:0]           csr_data
);
   import vqd_pkg::*;

   localparam int RES_BITS = $bits(vqd_result_type);

   logic [QD_W-1:0]  cap_ff, cap_in;
   vqd_genotype_type gt;
   logic             req_accept;
   logic             push;
   vqd_job_type      push_job;
   vqd_job_type      pop_job;
   logic             q_pop;
   logic             q_full;
   logic             q_empty;
   vqd_result_type   rsp;

   // Configuration register.
   assign csr_ready = 1'b1;
   assign cap_in    = (csr_valid && csr_ready) ? csr_data : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= QD_CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   // Unpack the request transaction into genotype fields.
   always_comb begin
      gt.carries_variant = req_tdata[0];
      gt.has_ad          = req_tdata[1];
      gt.ad_ref          = req_tdata[17:2];
      gt.ad_alt1         = req_tdata[33:18];
      gt.ad_alt2         = req_tdata[49:34];
      gt.ad_alt3         = req_tdata[65:50];
      gt.use_evidence    = req_tdata[66];
      gt.evidence_count  = req_tdata[82:67];
      gt.sample_dp       = req_tdata[98:83];
      gt.qual_valid      = req_tdata[99];
      gt.phred_qual      = req_tdata[123:100];
      gt.last            = req_tlast;
   end

   assign req_tready = !q_full;
   assign req_accept = req_tvalid && req_tready;

   vqd_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (req_accept),
      .gt     (gt),
      .push   (push),
      .job    (push_job)
   );

   vqd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (q_pop),
      .pop_job  (pop_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   vqd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_job     (pop_job),
      .q_pop     (q_pop),
      .qd_cap    (cap_ff),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   // Pack the response transaction, lowest field first.
   assign rsp_tdata = {{(RSP_TDATA_W - RES_BITS){1'b0}},
                       rsp.depth_used, rsp.qd, rsp.qd_valid};

`ifndef SYNTHESIS
   // The back end never takes a job from an empty queue.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("job taken from empty queue");

   // A last genotype always leaves a job waiting for the back end.
   a_last_queued: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> !q_empty)
      else $error("last genotype did not queue a job");

   // An invalid result carries a zero quotient.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[16:1] == '0))
      else $error("invalid result with nonzero quotient");
`endif

endmodule
